[rtl/cdas_pkg.sv]
// Package for the countdown alarm: mode, event and register codes, configuration type.
package cdas_pkg;

    localparam int SECONDS_WIDTH_DEF = 10;

    localparam int CFG_DATA_W   = 10;
    localparam int CFG_INDEX_W  = 2;
    localparam int MAX_SEC_W    = 10;
    localparam int STEP_W       = 8;
    localparam int SNOOZE_SEC_W = 10;
    localparam int SNOOZE_CNT_W = 3;
    localparam int OP_W         = 2;
    localparam int MODE_CODE_W  = 2;

    localparam logic [MAX_SEC_W-1:0]    SEL_LIMIT_RST      = 10'd600;
    localparam logic [STEP_W-1:0]       STEP_SECONDS_RST   = 8'd10;
    localparam logic [SNOOZE_SEC_W-1:0] SNOOZE_SECONDS_RST = 10'd10;
    localparam logic [SNOOZE_CNT_W-1:0] MAX_SNOOZES_RST    = 3'd5;

    localparam logic [CFG_INDEX_W-1:0] REG_SEL_LIMIT      = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_STEP_SECONDS   = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_SNOOZE_SECONDS = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_MAX_SNOOZES    = 2'd3;

    localparam logic [OP_W-1:0] OP_SECOND_TICK = 2'd0;
    localparam logic [OP_W-1:0] OP_BUTTON_SCAN = 2'd1;
    localparam logic [OP_W-1:0] OP_BUZZER_TICK = 2'd2;

    localparam logic [MODE_CODE_W-1:0] MODE_CODE_SELECT  = 2'd0;
    localparam logic [MODE_CODE_W-1:0] MODE_CODE_COUNT   = 2'd1;
    localparam logic [MODE_CODE_W-1:0] MODE_CODE_SNOOZED = 2'd2;
    localparam logic [MODE_CODE_W-1:0] MODE_CODE_ALARM   = 2'd3;

    typedef enum logic [3:0] {
        MODE_SELECT  = 4'b0001,
        MODE_COUNT   = 4'b0010,
        MODE_SNOOZED = 4'b0100,
        MODE_ALARM   = 4'b1000
    } t_mode;

    typedef struct packed {
        logic [MAX_SEC_W-1:0]    sel_limit;
        logic [STEP_W-1:0]       step_seconds;
        logic [SNOOZE_SEC_W-1:0] snooze_seconds;
        logic [SNOOZE_CNT_W-1:0] max_snoozes;
    } t_cfg;

    function automatic logic [MODE_CODE_W-1:0] mode_code(input t_mode m);
        logic [MODE_CODE_W-1:0] c;
        case (m)
            MODE_SELECT:  c = MODE_CODE_SELECT;
            MODE_COUNT:   c = MODE_CODE_COUNT;
            MODE_SNOOZED: c = MODE_CODE_SNOOZED;
            MODE_ALARM:   c = MODE_CODE_ALARM;
            default:      c = MODE_CODE_SELECT;
        endcase
        return c;
    endfunction

endpackage

[rtl/countdown_alarm_with_snooze_unit.sv]
// Top level of the countdown alarm with snooze: event register, state/result register.
//
//  channel  direction  handshake                  payload
//  in       input      i_in_valid / o_in_ready    i_op, i_up/down/enter_pressed
//  out      output     o_out_valid / i_out_ready  o_mode .. o_heartbeat
//  cfg      input      i_cfg_we                   i_cfg_index, i_cfg_data
//
// Request path: event register, then state register; one per cycle unless out stalls.
// The event register feeds the next-state logic, which loads the state register,
// and that register is the result shown on the out channel.
// A stalled result holds the state; the event register still takes one more request.
// Synchronous active-low reset: select mode, times and count zero, LED high.
module countdown_alarm_with_snooze_unit #(
    parameter int SECONDS_WIDTH = cdas_pkg::SECONDS_WIDTH_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [cdas_pkg::CFG_INDEX_W-1:0]   i_cfg_index,
    input  logic [cdas_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    input  logic                               i_in_valid,
    output logic                               o_in_ready,
    input  logic [cdas_pkg::OP_W-1:0]          i_op,
    input  logic                               i_up_pressed,
    input  logic                               i_down_pressed,
    input  logic                               i_enter_pressed,
    output logic                               o_out_valid,
    input  logic                               i_out_ready,
    output logic [cdas_pkg::MODE_CODE_W-1:0]   o_mode,
    output logic [SECONDS_WIDTH-1:0]           o_remaining_seconds,
    output logic [SECONDS_WIDTH-1:0]           o_selected_seconds,
    output logic [cdas_pkg::SNOOZE_CNT_W-1:0]  o_snoozes_done,
    output logic                               o_alarm_led,
    output logic                               o_buzzer_level,
    output logic                               o_heartbeat
);

    cdas_pkg::t_cfg cfg;

    logic                               r_in_valid;
    logic [cdas_pkg::OP_W-1:0]          r_op;
    logic                               r_up;
    logic                               r_down;
    logic                               r_enter;
    logic                               r_out_valid;

    cdas_pkg::t_mode                    r_mode;
    logic [SECONDS_WIDTH-1:0]           r_remaining;
    logic [SECONDS_WIDTH-1:0]           r_selected;
    logic [cdas_pkg::SNOOZE_CNT_W-1:0]  r_snoozes;
    logic                               r_led;
    logic                               r_buzzer;
    logic                               r_heartbeat;

    cdas_pkg::t_mode                    n_mode;
    logic [SECONDS_WIDTH-1:0]           n_remaining;
    logic [SECONDS_WIDTH-1:0]           n_selected;
    logic [cdas_pkg::SNOOZE_CNT_W-1:0]  n_snoozes;
    logic                               n_led;
    logic                               n_buzzer;
    logic                               n_heartbeat;

    logic advance;
    logic in_take;

    cdas_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    cdas_next_state #(
        .SECONDS_WIDTH (SECONDS_WIDTH)
    ) u_next (
        .i_op        (r_op),
        .i_up        (r_up),
        .i_down      (r_down),
        .i_enter     (r_enter),
        .i_cfg       (cfg),
        .i_mode      (r_mode),
        .i_remaining (r_remaining),
        .i_selected  (r_selected),
        .i_snoozes   (r_snoozes),
        .i_led       (r_led),
        .i_buzzer    (r_buzzer),
        .i_heartbeat (r_heartbeat),
        .o_mode      (n_mode),
        .o_remaining (n_remaining),
        .o_selected  (n_selected),
        .o_snoozes   (n_snoozes),
        .o_led       (n_led),
        .o_buzzer    (n_buzzer),
        .o_heartbeat (n_heartbeat)
    );

    assign advance    = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || advance;
    assign in_take    = i_in_valid && o_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_take) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_op    <= i_op;
            r_up    <= i_up_pressed;
            r_down  <= i_down_pressed;
            r_enter <= i_enter_pressed;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_mode      <= cdas_pkg::MODE_SELECT;
            r_remaining <= '0;
            r_selected  <= '0;
            r_snoozes   <= '0;
            r_led       <= 1'b1;
            r_buzzer    <= 1'b0;
            r_heartbeat <= 1'b0;
        end else begin
            if (advance) begin
                r_out_valid <= 1'b1;
                r_mode      <= n_mode;
                r_remaining <= n_remaining;
                r_selected  <= n_selected;
                r_snoozes   <= n_snoozes;
                r_led       <= n_led;
                r_buzzer    <= n_buzzer;
                r_heartbeat <= n_heartbeat;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid         = r_out_valid;
    assign o_mode              = cdas_pkg::mode_code(r_mode);
    assign o_remaining_seconds = r_remaining;
    assign o_selected_seconds  = r_selected;
    assign o_snoozes_done      = r_snoozes;
    assign o_alarm_led         = r_led;
    assign o_buzzer_level      = r_buzzer;
    assign o_heartbeat         = r_heartbeat;

    a_state_holds_without_advance: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        !advance |=> ($stable(r_mode) && $stable(r_remaining) && $stable(r_selected)
                      && $stable(r_snoozes) && $stable(r_led) && $stable(r_buzzer)
                      && $stable(r_heartbeat))
    ) else $error("state changed without an advancing request");

    a_not_ready_only_when_full: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> (r_in_valid && r_out_valid && !i_out_ready)
    ) else $error("input stalled while a stage is free");

    a_advance_yields_result: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        advance |=> o_out_valid
    ) else $error("advanced request produced no result");

    a_heartbeat_only_on_tick: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (advance && (r_op != cdas_pkg::OP_SECOND_TICK)) |=> $stable(r_heartbeat)
    ) else $error("heartbeat toggled on a non-tick request");

endmodule

[rtl/cdas_cfg_regs.sv]
// Configuration register bank for the countdown alarm.
module cdas_cfg_regs (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [cdas_pkg::CFG_INDEX_W-1:0]  i_cfg_index,
    input  logic [cdas_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    output cdas_pkg::t_cfg                    o_cfg
);

    cdas_pkg::t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.sel_limit      <= cdas_pkg::SEL_LIMIT_RST;
            r_cfg.step_seconds   <= cdas_pkg::STEP_SECONDS_RST;
            r_cfg.snooze_seconds <= cdas_pkg::SNOOZE_SECONDS_RST;
            r_cfg.max_snoozes    <= cdas_pkg::MAX_SNOOZES_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                cdas_pkg::REG_SEL_LIMIT: begin
                    r_cfg.sel_limit <= i_cfg_data[cdas_pkg::MAX_SEC_W-1:0];
                end
                cdas_pkg::REG_STEP_SECONDS: begin
                    r_cfg.step_seconds <= i_cfg_data[cdas_pkg::STEP_W-1:0];
                end
                cdas_pkg::REG_SNOOZE_SECONDS: begin
                    r_cfg.snooze_seconds <= i_cfg_data[cdas_pkg::SNOOZE_SEC_W-1:0];
                end
                cdas_pkg::REG_MAX_SNOOZES: begin
                    r_cfg.max_snoozes <= i_cfg_data[cdas_pkg::SNOOZE_CNT_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

[rtl/cdas_next_state.sv]
// Next-state logic of the countdown alarm for one event.
module cdas_next_state #(
    parameter int SECONDS_WIDTH = cdas_pkg::SECONDS_WIDTH_DEF
) (
    input  logic [cdas_pkg::OP_W-1:0]          i_op,
    input  logic                               i_up,
    input  logic                               i_down,
    input  logic                               i_enter,
    input  cdas_pkg::t_cfg                     i_cfg,
    input  cdas_pkg::t_mode                    i_mode,
    input  logic [SECONDS_WIDTH-1:0]           i_remaining,
    input  logic [SECONDS_WIDTH-1:0]           i_selected,
    input  logic [cdas_pkg::SNOOZE_CNT_W-1:0]  i_snoozes,
    input  logic                               i_led,
    input  logic                               i_buzzer,
    input  logic                               i_heartbeat,
    output cdas_pkg::t_mode                    o_mode,
    output logic [SECONDS_WIDTH-1:0]           o_remaining,
    output logic [SECONDS_WIDTH-1:0]           o_selected,
    output logic [cdas_pkg::SNOOZE_CNT_W-1:0]  o_snoozes,
    output logic                               o_led,
    output logic                               o_buzzer,
    output logic                               o_heartbeat
);

    localparam int SW = SECONDS_WIDTH;
    localparam int CW = (SW > cdas_pkg::CFG_DATA_W) ? SW : cdas_pkg::CFG_DATA_W;

    logic [CW-1:0] max_ext;
    logic [CW-1:0] snooze_ext;
    logic [SW-1:0] limit;
    logic [SW-1:0] snooze_len;
    logic [SW-1:0] step;
    logic [SW:0]   sum;
    logic          up_ok;
    logic [SW-1:0] sel_up;
    logic [SW-1:0] sel_dn;

    assign max_ext    = CW'(i_cfg.sel_limit);
    assign snooze_ext = CW'(i_cfg.snooze_seconds);
    assign limit      = max_ext[SW-1:0];
    assign snooze_len = snooze_ext[SW-1:0];
    assign step       = SW'(i_cfg.step_seconds);

    // up first, then down, both saturating
    assign sum    = {1'b0, i_selected} + {1'b0, step};
    assign up_ok  = i_up && (i_selected < limit);
    assign sel_up = !up_ok ? i_selected :
                    (sum > {1'b0, limit}) ? limit : sum[SW-1:0];
    assign sel_dn = !i_down ? sel_up :
                    (sel_up > step) ? (sel_up - step) : '0;

    always_comb begin
        o_mode      = i_mode;
        o_remaining = i_remaining;
        o_selected  = i_selected;
        o_snoozes   = i_snoozes;
        o_led       = i_led;
        o_buzzer    = i_buzzer;
        o_heartbeat = i_heartbeat;
        case (i_op)
            cdas_pkg::OP_SECOND_TICK: begin
                o_heartbeat = ~i_heartbeat;
                case (i_mode)
                    cdas_pkg::MODE_COUNT: begin
                        if (i_remaining != '0) begin
                            o_remaining = i_remaining - SW'(1);
                        end else begin
                            o_mode = cdas_pkg::MODE_ALARM;
                        end
                    end
                    cdas_pkg::MODE_SNOOZED: begin
                        if (i_snoozes == i_cfg.max_snoozes) begin
                            o_mode      = cdas_pkg::MODE_SELECT;
                            o_remaining = '0;
                            o_snoozes   = '0;
                        end else if (i_remaining != '0) begin
                            o_remaining = i_remaining - SW'(1);
                        end else begin
                            o_mode    = cdas_pkg::MODE_ALARM;
                            o_snoozes = i_snoozes + cdas_pkg::SNOOZE_CNT_W'(1);
                        end
                    end
                    cdas_pkg::MODE_ALARM: begin
                        o_led = ~i_led;
                    end
                    default: begin
                    end
                endcase
            end
            cdas_pkg::OP_BUTTON_SCAN: begin
                o_selected = sel_dn;
                if (i_enter) begin
                    case (i_mode)
                        cdas_pkg::MODE_SELECT: begin
                            o_mode      = cdas_pkg::MODE_COUNT;
                            o_remaining = sel_dn;
                        end
                        cdas_pkg::MODE_ALARM: begin
                            o_led       = 1'b0;
                            o_buzzer    = 1'b0;
                            o_remaining = snooze_len;
                            o_mode      = cdas_pkg::MODE_SNOOZED;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            cdas_pkg::OP_BUZZER_TICK: begin
                if (i_mode == cdas_pkg::MODE_ALARM) begin
                    o_buzzer = ~i_buzzer;
                end
            end
            default: begin
            end
        endcase
    end

endmodule

[dv/countdown_alarm_with_snooze_checker.sv]
// Checker for the countdown alarm: predicts each status result from the requests and compares it.
`timescale 1ns / 1ps

module countdown_alarm_with_snooze_checker #(
    parameter int SECONDS_WIDTH = cdas_pkg::SECONDS_WIDTH_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [cdas_pkg::CFG_INDEX_W-1:0]   i_cfg_index,
    input  logic [cdas_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    input  logic                               i_in_valid,
    input  logic                               i_in_ready,
    input  logic [cdas_pkg::OP_W-1:0]          i_op,
    input  logic                               i_up_pressed,
    input  logic                               i_down_pressed,
    input  logic                               i_enter_pressed,
    input  logic                               i_out_valid,
    input  logic                               i_out_ready,
    input  logic [cdas_pkg::MODE_CODE_W-1:0]   i_mode,
    input  logic [SECONDS_WIDTH-1:0]           i_remaining_seconds,
    input  logic [SECONDS_WIDTH-1:0]           i_selected_seconds,
    input  logic [cdas_pkg::SNOOZE_CNT_W-1:0]  i_snoozes_done,
    input  logic                               i_alarm_led,
    input  logic                               i_buzzer_level,
    input  logic                               i_heartbeat,
    output int                                 o_mismatches,
    output int                                 o_pending
);

    typedef struct packed {
        logic [cdas_pkg::MODE_CODE_W-1:0]  mode;
        logic [SECONDS_WIDTH-1:0]          remaining;
        logic [SECONDS_WIDTH-1:0]          selected;
        logic [cdas_pkg::SNOOZE_CNT_W-1:0] snoozes;
        logic                              led;
        logic                              buzzer;
        logic                              heartbeat;
    } t_status;

    cdas_pkg::t_cfg alarm_cfg;
    t_status        alarm_now;
    t_status        expected_status_q[$];
    int             mismatch_count = 0;
    int             pending_count = 0;

    assign o_mismatches = mismatch_count;
    assign o_pending    = pending_count;

    function automatic string status_text(input t_status s);
        return $sformatf("mode=%0d rem=%0d sel=%0d snoozes=%0d led=%0b buzzer=%0b hb=%0b",
                         s.mode, s.remaining, s.selected, s.snoozes, s.led, s.buzzer,
                         s.heartbeat);
    endfunction

    function automatic t_status next_status(input t_status s, input cdas_pkg::t_cfg c,
                                            input logic [cdas_pkg::OP_W-1:0] op,
                                            input logic up, input logic down,
                                            input logic enter);
        t_status                  n;
        logic [SECONDS_WIDTH-1:0] limit;
        int unsigned              sum;
        n     = s;
        limit = SECONDS_WIDTH'(c.sel_limit);
        case (op)
            cdas_pkg::OP_SECOND_TICK: begin
                n.heartbeat = ~s.heartbeat;
                if (s.mode == cdas_pkg::MODE_CODE_COUNT) begin
                    if (s.remaining != '0) n.remaining = s.remaining - 1'b1;
                    else n.mode = cdas_pkg::MODE_CODE_ALARM;
                end else if (s.mode == cdas_pkg::MODE_CODE_SNOOZED) begin
                    if (s.snoozes == c.max_snoozes) begin
                        n.mode      = cdas_pkg::MODE_CODE_SELECT;
                        n.remaining = '0;
                        n.snoozes   = '0;
                    end else if (s.remaining != '0) begin
                        n.remaining = s.remaining - 1'b1;
                    end else begin
                        n.mode    = cdas_pkg::MODE_CODE_ALARM;
                        n.snoozes = s.snoozes + 1'b1;
                    end
                end
                // LED only blinks on ticks that start in alarm
                if (s.mode == cdas_pkg::MODE_CODE_ALARM) n.led = ~s.led;
            end
            cdas_pkg::OP_BUTTON_SCAN: begin
                if (up && n.selected < limit) begin
                    sum        = n.selected + c.step_seconds;
                    n.selected = (sum > limit) ? limit : SECONDS_WIDTH'(sum);
                end
                if (down) begin
                    n.selected = (n.selected > c.step_seconds) ?
                                 SECONDS_WIDTH'(n.selected - c.step_seconds) : '0;
                end
                if (enter) begin
                    if (s.mode == cdas_pkg::MODE_CODE_SELECT) begin
                        n.mode      = cdas_pkg::MODE_CODE_COUNT;
                        n.remaining = n.selected;
                    end else if (s.mode == cdas_pkg::MODE_CODE_ALARM) begin
                        n.led       = 1'b0;
                        n.buzzer    = 1'b0;
                        n.remaining = SECONDS_WIDTH'(c.snooze_seconds);
                        n.mode      = cdas_pkg::MODE_CODE_SNOOZED;
                    end
                end
            end
            cdas_pkg::OP_BUZZER_TICK: begin
                if (s.mode == cdas_pkg::MODE_CODE_ALARM) n.buzzer = ~s.buzzer;
            end
            default: begin
            end
        endcase
        return n;
    endfunction

    always @(posedge i_clk) begin
        t_status got;
        t_status want;
        if (!i_rst_n) begin
            alarm_cfg.sel_limit      = cdas_pkg::SEL_LIMIT_RST;
            alarm_cfg.step_seconds   = cdas_pkg::STEP_SECONDS_RST;
            alarm_cfg.snooze_seconds = cdas_pkg::SNOOZE_SECONDS_RST;
            alarm_cfg.max_snoozes    = cdas_pkg::MAX_SNOOZES_RST;
            alarm_now.mode           = cdas_pkg::MODE_CODE_SELECT;
            alarm_now.remaining      = '0;
            alarm_now.selected       = '0;
            alarm_now.snoozes        = '0;
            alarm_now.led            = 1'b1;
            alarm_now.buzzer         = 1'b0;
            alarm_now.heartbeat      = 1'b0;
            expected_status_q.delete();
            pending_count = 0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    cdas_pkg::REG_SEL_LIMIT: begin
                        alarm_cfg.sel_limit = i_cfg_data[cdas_pkg::MAX_SEC_W-1:0];
                    end
                    cdas_pkg::REG_STEP_SECONDS: begin
                        alarm_cfg.step_seconds = i_cfg_data[cdas_pkg::STEP_W-1:0];
                    end
                    cdas_pkg::REG_SNOOZE_SECONDS: begin
                        alarm_cfg.snooze_seconds = i_cfg_data[cdas_pkg::SNOOZE_SEC_W-1:0];
                    end
                    cdas_pkg::REG_MAX_SNOOZES: begin
                        alarm_cfg.max_snoozes = i_cfg_data[cdas_pkg::SNOOZE_CNT_W-1:0];
                    end
                    default: begin
                    end
                endcase
            end
            if (i_out_valid && i_out_ready) begin
                got.mode      = i_mode;
                got.remaining = i_remaining_seconds;
                got.selected  = i_selected_seconds;
                got.snoozes   = i_snoozes_done;
                got.led       = i_alarm_led;
                got.buzzer    = i_buzzer_level;
                got.heartbeat = i_heartbeat;
                if (expected_status_q.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("%0t: unexpected status: %s", $realtime, status_text(got));
                end else begin
                    want = expected_status_q.pop_front();
                    pending_count--;
                    if (got.mode !== want.mode || got.remaining !== want.remaining ||
                        got.selected !== want.selected || got.snoozes !== want.snoozes ||
                        got.led !== want.led || got.buzzer !== want.buzzer ||
                        got.heartbeat !== want.heartbeat) begin
                        mismatch_count++;
                        if (mismatch_count <= 10) begin
                            $display("%0t: status mismatch", $realtime);
                            $display("  expected %s", status_text(want));
                            $display("  actual   %s", status_text(got));
                        end
                    end
                end
            end
            if (i_in_valid && i_in_ready) begin
                alarm_now = next_status(alarm_now, alarm_cfg, i_op, i_up_pressed,
                                        i_down_pressed, i_enter_pressed);
                expected_status_q.push_back(alarm_now);
                pending_count++;
            end
        end
    end

endmodule

[dv/tb_countdown_alarm_with_snooze_unit.sv]
// Testbench top for the countdown alarm: clock, reset, configuration phases and event stimulus.
`timescale 1ns / 1ps

module tb_countdown_alarm_with_snooze_unit;

    localparam int SECONDS_WIDTH = cdas_pkg::SECONDS_WIDTH_DEF;
    localparam logic [cdas_pkg::OP_W-1:0] OP_UNUSED = 2'd3;
    localparam int IDLE_PCT = 27;
    localparam int DRAIN_CYCLES = 4;

    logic                               clk;
    logic                               rst_n;
    logic                               cfg_we;
    logic [cdas_pkg::CFG_INDEX_W-1:0]   cfg_index;
    logic [cdas_pkg::CFG_DATA_W-1:0]    cfg_data;
    logic                               in_valid;
    logic                               in_ready;
    logic [cdas_pkg::OP_W-1:0]          ev_op;
    logic                               ev_up;
    logic                               ev_down;
    logic                               ev_enter;
    logic                               out_valid;
    logic                               out_ready = 1'b0;
    logic [cdas_pkg::MODE_CODE_W-1:0]   st_mode;
    logic [SECONDS_WIDTH-1:0]           st_remaining;
    logic [SECONDS_WIDTH-1:0]           st_selected;
    logic [cdas_pkg::SNOOZE_CNT_W-1:0]  st_snoozes;
    logic                               st_led;
    logic                               st_buzzer;
    logic                               st_heartbeat;
    logic                               steady = 1'b0;
    int                                 mismatches;
    int                                 pending;

    countdown_alarm_with_snooze_unit #(
        .SECONDS_WIDTH(SECONDS_WIDTH)
    ) uut (
        .i_clk              (clk),
        .i_rst_n            (rst_n),
        .i_cfg_we           (cfg_we),
        .i_cfg_index        (cfg_index),
        .i_cfg_data         (cfg_data),
        .i_in_valid         (in_valid),
        .o_in_ready         (in_ready),
        .i_op               (ev_op),
        .i_up_pressed       (ev_up),
        .i_down_pressed     (ev_down),
        .i_enter_pressed    (ev_enter),
        .o_out_valid        (out_valid),
        .i_out_ready        (out_ready),
        .o_mode             (st_mode),
        .o_remaining_seconds(st_remaining),
        .o_selected_seconds (st_selected),
        .o_snoozes_done     (st_snoozes),
        .o_alarm_led        (st_led),
        .o_buzzer_level     (st_buzzer),
        .o_heartbeat        (st_heartbeat)
    );

    countdown_alarm_with_snooze_checker #(
        .SECONDS_WIDTH(SECONDS_WIDTH)
    ) status_checker (
        .i_clk              (clk),
        .i_rst_n            (rst_n),
        .i_cfg_we           (cfg_we),
        .i_cfg_index        (cfg_index),
        .i_cfg_data         (cfg_data),
        .i_in_valid         (in_valid),
        .i_in_ready         (in_ready),
        .i_op               (ev_op),
        .i_up_pressed       (ev_up),
        .i_down_pressed     (ev_down),
        .i_enter_pressed    (ev_enter),
        .i_out_valid        (out_valid),
        .i_out_ready        (out_ready),
        .i_mode             (st_mode),
        .i_remaining_seconds(st_remaining),
        .i_selected_seconds (st_selected),
        .i_snoozes_done     (st_snoozes),
        .i_alarm_led        (st_led),
        .i_buzzer_level     (st_buzzer),
        .i_heartbeat        (st_heartbeat),
        .o_mismatches       (mismatches),
        .o_pending          (pending)
    );

    initial begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    always @(posedge clk) begin
        out_ready <= steady || ($urandom_range(0, 99) >= IDLE_PCT);
    end

    task automatic send_event(input logic [cdas_pkg::OP_W-1:0] op, input logic up,
                              input logic down, input logic enter);
        while (!steady && $urandom_range(0, 99) < IDLE_PCT) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        ev_op    <= op;
        ev_up    <= up;
        ev_down  <= down;
        ev_enter <= enter;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
    endtask

    task automatic send_random_events(input int count);
        int                        r;
        logic [cdas_pkg::OP_W-1:0] op;
        repeat (count) begin
            r = $urandom_range(0, 99);
            if (r < 50) op = cdas_pkg::OP_SECOND_TICK;
            else if (r < 85) op = cdas_pkg::OP_BUTTON_SCAN;
            else if (r < 97) op = cdas_pkg::OP_BUZZER_TICK;
            else op = OP_UNUSED;
            send_event(op, $urandom_range(0, 99) < 35, $urandom_range(0, 99) < 30,
                       $urandom_range(0, 99) < 30);
        end
    endtask

    // holds the sender until every status request has come back
    task automatic drain();
        in_valid <= 1'b0;
        @(negedge clk);
        while (pending != 0) @(negedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_config(input int max_s, input int step_s, input int snooze_s,
                                input int max_n);
        cfg_we    <= 1'b1;
        cfg_index <= cdas_pkg::REG_SEL_LIMIT;
        cfg_data  <= cdas_pkg::CFG_DATA_W'(max_s);
        @(posedge clk);
        cfg_index <= cdas_pkg::REG_STEP_SECONDS;
        cfg_data  <= cdas_pkg::CFG_DATA_W'(step_s);
        @(posedge clk);
        cfg_index <= cdas_pkg::REG_SNOOZE_SECONDS;
        cfg_data  <= cdas_pkg::CFG_DATA_W'(snooze_s);
        @(posedge clk);
        cfg_index <= cdas_pkg::REG_MAX_SNOOZES;
        cfg_data  <= cdas_pkg::CFG_DATA_W'(max_n);
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    // short limits most of the time so countdowns actually expire
    task automatic write_random_config();
        int max_s;
        int step_s;
        int snooze_s;
        max_s    = ($urandom_range(0, 3) != 0) ? $urandom_range(0, 40) : $urandom_range(0, 1023);
        step_s   = ($urandom_range(0, 9) < 7) ? $urandom_range(1, 15) : $urandom_range(1, 255);
        snooze_s = ($urandom_range(0, 3) != 0) ? $urandom_range(0, 8) : $urandom_range(0, 1023);
        write_config(max_s, step_s, snooze_s, $urandom_range(0, 7));
    endtask

    initial begin
        rst_n     = 1'b0;
        cfg_we    = 1'b0;
        cfg_index = cdas_pkg::REG_SEL_LIMIT;
        cfg_data  = '0;
        in_valid  = 1'b0;
        ev_op     = cdas_pkg::OP_SECOND_TICK;
        ev_up     = 1'b0;
        ev_down   = 1'b0;
        ev_enter  = 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_random_events(120);

        drain();
        write_config(3, 2, 0, 7);
        send_event(OP_UNUSED, 1'b1, 1'b1, 1'b1);
        send_event(cdas_pkg::OP_BUTTON_SCAN, 1'b0, 1'b1, 1'b0);
        send_event(cdas_pkg::OP_BUTTON_SCAN, 1'b1, 1'b0, 1'b0);
        send_event(cdas_pkg::OP_BUTTON_SCAN, 1'b1, 1'b0, 1'b0);
        send_event(cdas_pkg::OP_BUTTON_SCAN, 1'b1, 1'b1, 1'b1);
        send_event(cdas_pkg::OP_BUTTON_SCAN, 1'b0, 1'b0, 1'b1);
        send_event(cdas_pkg::OP_BUZZER_TICK, 1'b0, 1'b0, 1'b0);
        send_event(cdas_pkg::OP_SECOND_TICK, 1'b0, 1'b0, 1'b0);
        send_event(cdas_pkg::OP_SECOND_TICK, 1'b0, 1'b0, 1'b0);
        send_event(cdas_pkg::OP_BUZZER_TICK, 1'b0, 1'b0, 1'b0);
        send_event(cdas_pkg::OP_SECOND_TICK, 1'b0, 1'b0, 1'b0);
        send_event(cdas_pkg::OP_BUTTON_SCAN, 1'b0, 1'b0, 1'b1);
        send_event(cdas_pkg::OP_SECOND_TICK, 1'b0, 1'b0, 1'b0);
        send_event(cdas_pkg::OP_BUTTON_SCAN, 1'b0, 1'b0, 1'b1);

        // snooze limit dropped below the count: count wraps before matching
        drain();
        write_config(3, 2, 0, 0);
        repeat (7) begin
            send_event(cdas_pkg::OP_SECOND_TICK, 1'b0, 1'b0, 1'b0);
            send_event(cdas_pkg::OP_BUTTON_SCAN, 1'b0, 1'b0, 1'b1);
        end
        send_event(cdas_pkg::OP_SECOND_TICK, 1'b0, 1'b0, 1'b0);

        drain();
        write_config(1023, 255, 1023, 7);
        send_random_events(120);

        drain();
        write_config(0, 1, 0, 0);
        send_random_events(120);

        for (int phase = 0; phase < 9; phase++) begin
            drain();
            write_random_config();
            steady = (phase == 3);
            send_random_events((phase == 3) ? 300 : 110);
        end
        steady = 1'b0;

        drain();
        if (mismatches == 0 && pending == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

    initial begin
        #1_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

endmodule

[sim.f]
rtl/cdas_pkg.sv
rtl/cdas_cfg_regs.sv
rtl/cdas_next_state.sv
rtl/countdown_alarm_with_snooze_unit.sv
dv/countdown_alarm_with_snooze_checker.sv
dv/tb_countdown_alarm_with_snooze_unit.sv
